@@ hw/rtl/ihm_pkg.sv @@
// types, constants and codes shared by the interval histogram monitor
`timescale 1ns / 1ps
`default_nettype none
package ihm_pkg;

  localparam int unsigned NUM_BINS = 1024;
  localparam int unsigned BIN_AW   = $clog2(NUM_BINS);
  localparam int unsigned BIN_CW   = 32;
  localparam int unsigned BIN_SW   = 64;
  localparam int unsigned BIN_DW   = BIN_CW + BIN_SW;
  localparam int unsigned CNT_W    = 40;
  localparam int unsigned CFG_W    = 32;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic CFG_CYCLES_PER_BIN = 1'b0;
  localparam logic CFG_BINS_IN_USE    = 1'b1;

  localparam logic [31:0] CYCLES_PER_BIN_RST = 32'd1000;
  localparam logic [10:0] BINS_IN_USE_RST    = 11'd1024;

  localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [BIN_CW-1:0] BIN_CNT_MAX = {BIN_CW{1'b1}};

  typedef enum logic [1:0] {
    K_START,
    K_SAMPLE,
    K_READ,
    K_NONE
  } kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] timestamp;
    logic [9:0]  read_bin;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] timestamp;
    logic [9:0]  read_bin;
  } cmd_t;

  typedef struct packed {
    logic [39:0] sample_count;
    logic [63:0] min_delta;
    logic [39:0] min_index;
    logic [63:0] max_delta;
    logic [39:0] max_index;
    logic [63:0] delta_total;
    logic [63:0] mean_delta;
    logic [9:0]  bin_index;
    logic [31:0] bin_count;
    logic [63:0] bin_sum;
  } out_t;

endpackage
`default_nettype wire

@@ hw/rtl/ihm_ram.sv @@
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ihm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

@@ hw/rtl/ihm_front.sv @@
// input queue and op decode
`timescale 1ns / 1ps
`default_nettype none
module ihm_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire ihm_pkg::in_t in_item_i,
  output logic              cmd_valid_o,
  input  wire logic         cmd_pop_i,
  output ihm_pkg::cmd_t     cmd_o
);

  ihm_pkg::in_t ent_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_o.timestamp = ent_q[rp_q].timestamp;
    cmd_o.read_bin  = ent_q[rp_q].read_bin;
    case (ent_q[rp_q].op)
      ihm_pkg::OP_START:  cmd_o.kind = ihm_pkg::K_START;
      ihm_pkg::OP_SAMPLE: cmd_o.kind = ihm_pkg::K_SAMPLE;
      ihm_pkg::OP_READ:   cmd_o.kind = ihm_pkg::K_READ;
      default:            cmd_o.kind = ihm_pkg::K_NONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ihm_div.sv @@
// iterative 64 by 64 bit restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ihm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic      [63:0] quo_o
);

  logic        busy_q;
  logic [6:0]  step_q;
  logic [63:0] rem_q, den_q;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_o[63]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 7'd0;
      done_o <= 1'b0;
      rem_q  <= 64'd0;
      den_q  <= 64'd0;
      quo_o  <= 64'd0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 7'd0;
        rem_q  <= 64'd0;
        den_q  <= den_i;
        quo_o  <= num_i;
      end else if (busy_q) begin
        rem_q  <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
        quo_o  <= {quo_o[62:0], fits};
        step_q <= step_q + 7'd1;
        if (step_q == 7'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ihm_back.sv @@
// statistics, bin memory update and result register
`timescale 1ns / 1ps
`default_nettype none
module ihm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   cycles_per_bin_i,
  input  wire logic [10:0]   bins_in_use_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  input  wire ihm_pkg::cmd_t cmd_i,
  output logic               empty,
  input  wire logic          pop,
  output ihm_pkg::out_t      out_item_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_LOOK,
    S_UPD
  } state_e;

  localparam int unsigned AW = ihm_pkg::BIN_AW;

  state_e              state_q;
  ihm_pkg::kind_e      kind_q;
  logic [63:0]         last_q, least_q, most_q, total_q, dt_q, mean_q;
  logic [39:0]         count_q, least_at_q, most_at_q;
  logic [AW-1:0]       bin_q, clr_q;
  logic [9:0]          rb_q;
  logic                rb_ok_q, need_div_q, res_on_clear_q, res_valid_q;
  ihm_pkg::out_t       res_q;

  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [ihm_pkg::BIN_DW-1:0] ram_wdata, ram_rdata;
  logic                div_start, div_done;
  logic [63:0]         div_num, div_den, div_quo;
  logic [63:0]         dt_c, quo_c;
  logic [31:0]         lim;
  logic [AW-1:0]       bin_c;
  logic [31:0]         cnt_old, cnt_new;
  logic [63:0]         sum_new;

  assign empty      = !res_valid_q;
  assign out_item_o = res_q;
  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i && !res_valid_q;
  assign dt_c       = cmd_i.timestamp - last_q;

  always_comb begin
    if (bins_in_use_i == 11'd0) begin
      lim = 32'd1;
    end else if (32'(bins_in_use_i) > ihm_pkg::NUM_BINS) begin
      lim = ihm_pkg::NUM_BINS;
    end else begin
      lim = 32'(bins_in_use_i);
    end
    quo_c = need_div_q ? div_quo : 64'd0;
    if (cycles_per_bin_i == 32'd0 || quo_c >= 64'(lim)) begin
      bin_c = AW'(lim - 32'd1);
    end else begin
      bin_c = AW'(quo_c);
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = total_q;
    div_den   = 64'(count_q);
    if (cmd_pop_o) begin
      if (cmd_i.kind == ihm_pkg::K_SAMPLE && cycles_per_bin_i != 32'd0) begin
        div_start = 1'b1;
        div_num   = dt_c;
        div_den   = 64'(cycles_per_bin_i);
      end else if (cmd_i.kind == ihm_pkg::K_READ && count_q != 40'd0) begin
        div_start = 1'b1;
      end
    end
  end

  assign cnt_old   = ram_rdata[ihm_pkg::BIN_DW-1 -: ihm_pkg::BIN_CW];
  assign cnt_new   = (cnt_old == ihm_pkg::BIN_CNT_MAX) ? cnt_old : cnt_old + 32'd1;
  assign sum_new   = ram_rdata[ihm_pkg::BIN_SW-1:0] + dt_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = bin_q;
    ram_wdata = {cnt_new, sum_new};
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_UPD && kind_q == ihm_pkg::K_SAMPLE) begin
      ram_we = 1'b1;
    end
  end

  ihm_ram #(
    .Width (ihm_pkg::BIN_DW),
    .Depth (ihm_pkg::NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  ihm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      kind_q         <= ihm_pkg::K_NONE;
      last_q         <= 64'd0;
      count_q        <= 40'd0;
      least_q        <= 64'd0;
      least_at_q     <= 40'd0;
      most_q         <= 64'd0;
      most_at_q      <= 40'd0;
      total_q        <= 64'd0;
      dt_q           <= 64'd0;
      mean_q         <= 64'd0;
      bin_q          <= '0;
      clr_q          <= '0;
      rb_q           <= 10'd0;
      rb_ok_q        <= 1'b0;
      need_div_q     <= 1'b0;
      res_on_clear_q <= 1'b0;
      res_valid_q    <= 1'b0;
      res_q          <= '0;
    end else begin
      if (pop && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(ihm_pkg::NUM_BINS - 1)) begin
            state_q <= S_IDLE;
            if (res_on_clear_q) begin
              res_q       <= '0;
              res_valid_q <= 1'b1;
            end
          end
        end
        S_IDLE: begin
          if (cmd_pop_o) begin
            kind_q     <= cmd_i.kind;
            need_div_q <= div_start;
            rb_q       <= cmd_i.read_bin;
            rb_ok_q    <= (32'(cmd_i.read_bin) < ihm_pkg::NUM_BINS);
            case (cmd_i.kind)
              ihm_pkg::K_START: begin
                last_q         <= cmd_i.timestamp;
                count_q        <= 40'd0;
                least_q        <= 64'd0;
                least_at_q     <= 40'd0;
                most_q         <= 64'd0;
                most_at_q      <= 40'd0;
                total_q        <= 64'd0;
                clr_q          <= '0;
                res_on_clear_q <= 1'b1;
                state_q        <= S_CLEAR;
              end
              ihm_pkg::K_SAMPLE: begin
                dt_q    <= dt_c;
                last_q  <= cmd_i.timestamp;
                total_q <= total_q + dt_c;
                if (count_q == 40'd0) begin
                  least_q    <= dt_c;
                  most_q     <= dt_c;
                  least_at_q <= 40'd0;
                  most_at_q  <= 40'd0;
                end else if (least_q > dt_c) begin
                  least_q    <= dt_c;
                  least_at_q <= count_q;
                end else if (most_q < dt_c) begin
                  most_q    <= dt_c;
                  most_at_q <= count_q;
                end
                if (count_q != ihm_pkg::CNT_MAX) begin
                  count_q <= count_q + 40'd1;
                end
                state_q <= S_DIV;
              end
              ihm_pkg::K_READ: begin
                state_q <= S_DIV;
              end
              default: begin
                res_q       <= '0;
                res_valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_DIV: begin
          if (!need_div_q || div_done) begin
            if (kind_q == ihm_pkg::K_SAMPLE) begin
              bin_q <= bin_c;
            end else begin
              bin_q  <= AW'(rb_q);
              mean_q <= quo_c;
            end
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          res_q.sample_count <= count_q;
          res_q.min_delta    <= least_q;
          res_q.min_index    <= least_at_q;
          res_q.max_delta    <= most_q;
          res_q.max_index    <= most_at_q;
          res_q.delta_total  <= total_q;
          if (kind_q == ihm_pkg::K_SAMPLE) begin
            res_q.mean_delta <= 64'd0;
            res_q.bin_index  <= 10'(bin_q);
            res_q.bin_count  <= cnt_new;
            res_q.bin_sum    <= sum_new;
          end else begin
            res_q.mean_delta <= mean_q;
            res_q.bin_index  <= rb_q;
            res_q.bin_count  <= rb_ok_q ? cnt_old : 32'd0;
            res_q.bin_sum    <= rb_ok_q ? ram_rdata[ihm_pkg::BIN_SW-1:0] : 64'd0;
          end
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !res_valid_q)
    else $error("command taken while result slot busy");

  a_ram_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_UPD))
    else $error("bin memory written outside clear or update");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV && need_div_q))
    else $error("divider finished with no consumer");

  a_clear_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && clr_q == AW'(ihm_pkg::NUM_BINS - 1)) |=> state_q == S_IDLE)
    else $error("clear pass did not end");

endmodule
`default_nettype wire

@@ hw/rtl/interval_histogram_monitor_core.sv @@
// top level of the interval histogram monitor
//
// channel   | direction | handshake                 | payload
// input     | in        | push / full               | in_item_i  (ihm_pkg::in_t)
// result    | out       | empty / pop               | out_item_o (ihm_pkg::out_t)
// config    | in        | cfg_we_i, cfg_idx_i       | cfg_data_i (32 bit)
//
// sample and read wait for the one bit per cycle divider
// a sample with zero bin width or a read with no samples skips the divider
// start clears the bin memory, one bin memory row cleared per cycle
// after reset a clearing pass over all NUM_BINS rows runs before the first item
// a two entry input queue keeps taking items, until it is full, while the back end is busy
// or its result register waits for a pop
`timescale 1ns / 1ps
`default_nettype none
module interval_histogram_monitor_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire ihm_pkg::in_t in_item_i,
  output logic              empty,
  input  wire logic         pop,
  output ihm_pkg::out_t     out_item_o,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [ihm_pkg::CFG_W-1:0] cfg_data_i
);

  logic [31:0]   cycles_per_bin_q;
  logic [10:0]   bins_in_use_q;
  logic          cmd_valid, cmd_pop;
  ihm_pkg::cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycles_per_bin_q <= ihm_pkg::CYCLES_PER_BIN_RST;
      bins_in_use_q    <= ihm_pkg::BINS_IN_USE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ihm_pkg::CFG_CYCLES_PER_BIN: cycles_per_bin_q <= cfg_data_i[31:0];
        ihm_pkg::CFG_BINS_IN_USE:    bins_in_use_q    <= cfg_data_i[10:0];
        default:                     ;
      endcase
    end
  end

  ihm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  ihm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cycles_per_bin_i (cycles_per_bin_q),
    .bins_in_use_i    (bins_in_use_q),
    .cmd_valid_i      (cmd_valid),
    .cmd_pop_o        (cmd_pop),
    .cmd_i            (cmd),
    .empty            (empty),
    .pop              (pop),
    .out_item_o       (out_item_o)
  );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// self-checking testbench for the interval histogram monitor core
`timescale 1ns / 1ps
module testbench;
  import ihm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  interval_histogram_monitor_core uut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [31:0] bin_width;
  logic [10:0] bins_active;
  logic [63:0] prev_stamp, low_delta, high_delta, delta_sum;
  logic [39:0] n_samples, low_at, high_at;
  logic [31:0] tally [NUM_BINS];
  logic [63:0] tally_sum [NUM_BINS];

  in_t  stim_q [$];
  out_t stats_q [$];
  int   mismatches = 0;
  int   stalls = 0;
  bit   timed_out = 0;

  function automatic out_t predict_stats(in_t it);
    out_t r;
    logic [63:0] dt, b;
    logic [10:0] lim;
    r = '0;
    if (it.op == OP_START) begin
      prev_stamp = it.timestamp;
      n_samples = '0; low_delta = '0; low_at = '0;
      high_delta = '0; high_at = '0; delta_sum = '0;
      for (int i = 0; i < NUM_BINS; i++) begin
        tally[i] = '0; tally_sum[i] = '0;
      end
    end else if (it.op == OP_SAMPLE || it.op == OP_READ) begin
      if (it.op == OP_SAMPLE) begin
        dt = it.timestamp - prev_stamp;
        lim = (bins_active == 0) ? 11'd1 : (bins_active > NUM_BINS) ? 11'(NUM_BINS)
                                                                    : bins_active;
        delta_sum += dt;
        if (n_samples == 0) begin
          low_delta = dt; high_delta = dt; low_at = '0; high_at = '0;
        end else if (low_delta > dt) begin
          low_delta = dt; low_at = n_samples;
        end else if (high_delta < dt) begin
          high_delta = dt; high_at = n_samples;
        end
        if (n_samples != CNT_MAX) n_samples++;
        b = (bin_width == 0) ? 64'(lim - 1) : dt / 64'(bin_width);
        if (b >= 64'(lim)) b = 64'(lim - 1);
        if (tally[b] != BIN_CNT_MAX) tally[b]++;
        tally_sum[b] += dt;
        prev_stamp = it.timestamp;
        r.bin_index = b[9:0];
        r.bin_count = tally[b];
        r.bin_sum = tally_sum[b];
      end else begin
        r.mean_delta = (n_samples != 0) ? delta_sum / 64'(n_samples) : '0;
        r.bin_index = it.read_bin;
        r.bin_count = tally[it.read_bin];
        r.bin_sum = tally_sum[it.read_bin];
      end
      r.sample_count = n_samples; r.min_delta = low_delta; r.min_index = low_at;
      r.max_delta = high_delta; r.max_index = high_at; r.delta_total = delta_sum;
    end
    return r;
  endfunction

  // driver
  int push_wait = 0;
  always @(posedge clk_i) begin
    if (push && !full) begin
      stats_q.push_back(predict_stats(stim_q.pop_front()));
      push_wait <= $urandom_range(0, 16) * ($urandom_range(0, 3) != 0);
      push <= 1'b0;
    end else if (rst_ni && !push && stim_q.size() != 0) begin
      if (push_wait > 0) push_wait <= push_wait - 1;
      else begin
        in_item_i <= stim_q[0];
        push <= 1'b1;
      end
    end
  end

  // monitor
  int pop_wait = 0;
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (stats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %p", out_item_o);
      end else begin
        out_t e;
        e = stats_q.pop_front();
        if (e !== out_item_o) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_item_o);
        end
      end
      pop_wait <= $urandom_range(0, 16) * ($urandom_range(0, 3) != 0);
      pop <= 1'b0;
    end else if (pop_wait > 0) pop_wait <= pop_wait - 1;
    else pop <= 1'b1;
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) stalls <= 0;
    else stalls <= stalls + 1;
    if (stalls > 20000) timed_out = 1'b1;
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CYCLES_PER_BIN) bin_width = val;
    else bins_active = val[10:0];
  endtask

  task automatic wait_drained();
    wait ((stim_q.size() == 0 && stats_q.size() == 0 && !push) || timed_out);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic in_t make_item(logic [1:0] op, logic [63:0] ts, logic [9:0] rb);
    in_t it;
    it.op = op; it.timestamp = ts; it.read_bin = rb;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  logic [63:0] stamp;

  initial begin
    bin_width = CYCLES_PER_BIN_RST;
    bins_active = BINS_IN_USE_RST;
    void'(predict_stats(make_item(OP_START, '0, '0)));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    stim_q.push_back(make_item(OP_READ, '0, '0));
    stim_q.push_back(make_item(OP_SAMPLE, 64'd5000, '0));
    stim_q.push_back(make_item(OP_START, '1, 10'h3ff));
    stim_q.push_back(make_item(OP_SAMPLE, 64'd999, '0));
    stim_q.push_back(make_item(OP_SAMPLE, 64'd1000, '0));
    stim_q.push_back(make_item(OP_SAMPLE, 64'd3000, '0));
    stim_q.push_back(make_item(OP_SAMPLE, 64'd3000, '0));
    stim_q.push_back(make_item(OP_SAMPLE, '1, '0));
    stim_q.push_back(make_item(OP_SAMPLE, 64'd10, '0));
    stim_q.push_back(make_item(2'd3, rand64(), 10'h155));
    stim_q.push_back(make_item(OP_READ, '0, 10'h3ff));
    stim_q.push_back(make_item(OP_READ, '1, 10'd2));
    stim_q.push_back(make_item(OP_READ, '0, 10'd1023));
    wait_drained();

    // random phases with various settings
    for (int ph = 0; ph < 8 && !timed_out; ph++) begin
      case (ph)
        0: begin write_reg(CFG_CYCLES_PER_BIN, 32'd0); write_reg(CFG_BINS_IN_USE, 32'd1); end
        1: begin write_reg(CFG_CYCLES_PER_BIN, '1); write_reg(CFG_BINS_IN_USE, 32'd0); end
        2: begin write_reg(CFG_CYCLES_PER_BIN, 32'd1); write_reg(CFG_BINS_IN_USE, 32'd2047); end
        3: begin write_reg(CFG_CYCLES_PER_BIN, 32'd1); write_reg(CFG_BINS_IN_USE, 32'd1024); end
        default: begin
          write_reg(CFG_CYCLES_PER_BIN, $urandom_range(1, 64) << $urandom_range(0, 20));
          write_reg(CFG_BINS_IN_USE, $urandom_range(0, 2047));
        end
      endcase
      stamp = rand64();
      stim_q.push_back(make_item(OP_START, stamp, '0));
      for (int i = 0; i < 118; i++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 9) == 0) stamp = rand64();
          else stamp += $urandom_range(0, 3) == 0 ? 64'($urandom_range(0, 50))
                                                 : 64'($urandom) >> $urandom_range(0, 31);
          stim_q.push_back(make_item(OP_SAMPLE, stamp, '0));
        end else if (r < 93) stim_q.push_back(make_item(OP_READ, rand64(),
                                              $urandom_range(0, 3) == 0 ? 10'($urandom)
                                                                        : 10'($urandom_range(0, 15))));
        else if (r < 96) stim_q.push_back(make_item(2'd3, rand64(), 10'($urandom)));
        else begin
          stamp = rand64();
          stim_q.push_back(make_item(OP_START, stamp, 10'($urandom)));
        end
      end
      wait_drained();
    end

    if (!timed_out && mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
